// ===== src/wheel_speed_incremental_pid_core_macros.svh =====
// ----------------------------------------------------------------------------
// wheel speed pid core assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_INCREMENTAL_PID_CORE_MACROS_SVH
`define WHEEL_SPEED_INCREMENTAL_PID_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WSIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WSIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wsip_pkg.sv =====
// ----------------------------------------------------------------------------
// wsip_pkg
// widths, constants, register indexes and control types of the pid core
// ----------------------------------------------------------------------------
package wsip_pkg;

	localparam int GAIN_W      = 24;
	localparam int OMAX_W      = 15;
	localparam int MASK_W      = 4;
	localparam int CFG_W       = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int INTEG_W     = 13;
	localparam int ACC_W       = 24;
	localparam int PWM_W       = 16;
	localparam int PCT_W       = 8;
	localparam int FRAC_W      = 8;
	localparam int GAIN_FRAC_W = 16;
	localparam int DIVQ_W      = 9;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int DIV_STEPS   = OMAX_W;
	localparam int CNT_W       = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_MASK   = 3'd5;

	// reset values of the registers
	localparam logic [GAIN_W-1:0] GAIN_P_RST     = 24'd340787;
	localparam logic [GAIN_W-1:0] GAIN_I_RST     = 24'd1966;
	localparam logic [GAIN_W-1:0] GAIN_D_RST     = 24'd0;
	localparam logic [OMAX_W-1:0] OUTPUT_MAX_RST = 15'd1000;
	localparam logic [OMAX_W-1:0] DEAD_BAND_RST  = 15'd0;
	localparam logic [MASK_W-1:0] DIR_MASK_RST   = 4'd0;

	// loop constants
	localparam int INTEG_LIMIT       = 2560;     // 10.0 in q.8
	localparam int INTEG_SMALL_LIMIT = 51;       // 0.2 in q.8
	localparam int KIE_SMALL_MAX     = 1677721;  // largest |ki*e| below 0.1 in q.24
	localparam int PCT_FULL          = 100;
	localparam int RECIP_100         = 5243;     // 2^19 / 100, exact for 15 bit values

	typedef struct packed {
		logic accept;
		logic diff;
		logic mul_i;
		logic integ;
		logic mul_d;
		logic sum;
		logic acc;
		logic pwm;
		logic div_step;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic out_free;
	} sts_t;

endpackage

// ===== src/wsip_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsip_ctrl
// sequencer of the pid core: steps the datapath through one item
// ----------------------------------------------------------------------------
module wsip_ctrl
	import wsip_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] ST_DIFF  = 4'd1;
	localparam logic [ST_W-1:0] ST_MULI  = 4'd2;
	localparam logic [ST_W-1:0] ST_INTEG = 4'd3;
	localparam logic [ST_W-1:0] ST_MULD  = 4'd4;
	localparam logic [ST_W-1:0] ST_SUM   = 4'd5;
	localparam logic [ST_W-1:0] ST_ACC   = 4'd6;
	localparam logic [ST_W-1:0] ST_PWM   = 4'd7;
	localparam logic [ST_W-1:0] ST_DIV   = 4'd8;
	localparam logic [ST_W-1:0] ST_DONE  = 4'd9;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic [ST_W-1:0]  state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = sts.skip ? ST_DONE : ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MULI;
			end
			ST_MULI: begin
				cmd.mul_i = 1'b1;
				state_d   = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.integ = 1'b1;
				state_d   = ST_MULD;
			end
			ST_MULD: begin
				cmd.mul_d = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_PWM;
			end
			ST_PWM: begin
				cmd.pwm = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.out_ld = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ===== src/wsip_dpath.sv =====
// ----------------------------------------------------------------------------
// wsip_dpath
// pid datapath: per-motor state, shared multiplier, pwm shaping, divider
// ----------------------------------------------------------------------------
module wsip_dpath
	import wsip_pkg::*;
#(
	parameter int MOTOR_COUNT = 4,
	parameter int SPEED_WIDTH = 24,
	parameter int IDX_W       = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output sts_t                          sts,
	input  logic signed [GAIN_W-1:0]      gain_p,
	input  logic signed [GAIN_W-1:0]      gain_i,
	input  logic signed [GAIN_W-1:0]      gain_d,
	input  logic        [OMAX_W-1:0]      output_max,
	input  logic        [OMAX_W-1:0]      dead_band,
	input  logic        [MASK_W-1:0]      direction_mask,
	input  logic        [IDX_W-1:0]       motor_index,
	input  logic signed [SPEED_WIDTH-1:0] target_speed,
	input  logic signed [SPEED_WIDTH-1:0] measured_speed,
	input  logic                          stop,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic signed [PWM_W-1:0]       pwm_value,
	output logic signed [PCT_W-1:0]       drive_percent
);

	localparam int EW   = SPEED_WIDTH + 1;
	localparam int DW   = SPEED_WIDTH + 3;
	localparam int PW   = GAIN_W + DW;
	localparam int SUMW = PW + 2;
	localparam int RW   = PW - GAIN_FRAC_W;
	localparam int AW   = SUMW - GAIN_FRAC_W + 1;
	localparam int MAG_W = OMAX_W;

	localparam logic signed [PW-1:0]   KIE_HI    = PW'(KIE_SMALL_MAX);
	localparam logic signed [PW-1:0]   KIE_LO    = -KIE_HI;
	localparam logic signed [PW-1:0]   HALF_P    = PW'(1) <<< (GAIN_FRAC_W - 1);
	localparam logic signed [SUMW-1:0] HALF_S    = SUMW'(1) <<< (GAIN_FRAC_W - 1);
	localparam logic signed [RW-1:0]   LIM_BIG   = RW'(INTEG_LIMIT);
	localparam logic signed [RW-1:0]   LIM_SMALL = RW'(INTEG_SMALL_LIMIT);

	// per-motor loop state
	logic signed [EW-1:0]      last_err_q [MOTOR_COUNT];
	logic signed [EW-1:0]      prev_err_q [MOTOR_COUNT];
	logic signed [INTEG_W-1:0] integ_mem_q[MOTOR_COUNT];
	logic signed [ACC_W-1:0]   acc_mem_q  [MOTOR_COUNT];

	logic signed [EW-1:0]      e_q;
	logic        [IDX_W-1:0]   idx_q;
	logic                      skip_q;
	logic signed [DW-1:0]      dp_q, dd_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [SUMW-1:0]    sum_q;
	logic        [DIVQ_W-1:0]  divq_q;
	logic        [MAG_W-1:0]   mag_q, quo_q;
	logic                      neg_q;
	logic        [DIVQ_W-1:0]  rem_q;
	logic                      out_valid_q;

	logic signed [EW-1:0]            e_in, e1, e2;
	logic signed [INTEG_W-1:0]       integ_old;
	logic signed [ACC_W-1:0]         acc_old;
	logic [OMAX_W+RECIP_W-1:0]       om_prod;
	logic [DIVQ_W-1:0]               divq_d;
	logic signed [GAIN_W-1:0]        mul_a;
	logic signed [DW-1:0]            mul_b;
	logic signed [PW-1:0]            prod_d;
	logic                            kie_small;
	logic signed [PW-1:0]            kie_r;
	logic signed [RW-1:0]            integ_sum, integ_lim;
	logic signed [INTEG_W-1:0]       integ_new;
	logic signed [SUMW-1:0]          sum_r;
	logic signed [AW-1:0]            acc_sum, acc_lim;
	logic signed [ACC_W-1:0]         acc_new;
	logic        [ACC_W-1:0]         acc_abs;
	logic        [MAG_W-1:0]         mag_raw, mag_db;
	logic        [15:0]              dir_ext;
	logic                            dir_bit;
	logic        [DIVQ_W:0]          trial, trial_sub;
	logic                            ge;
	logic        [PCT_W-2:0]         pct_mag;
	logic        [MAG_W-1:0]         pct_full_w;

	assign e_in = EW'(target_speed) - EW'(measured_speed);

	assign sts.skip     = stop || ({1'b0, motor_index} >= (IDX_W + 1)'(MOTOR_COUNT));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign e1        = last_err_q[idx_q];
	assign e2        = prev_err_q[idx_q];
	assign integ_old = integ_mem_q[idx_q];
	assign acc_old   = acc_mem_q[idx_q];

	// percent divisor output_max/100 by reciprocal, never below 1
	assign om_prod = (OMAX_W + RECIP_W)'(output_max) * (OMAX_W + RECIP_W)'(RECIP_100);
	assign divq_d  = (om_prod[OMAX_W+RECIP_W-1 -: DIVQ_W] == '0) ? DIVQ_W'(1)
	                 : om_prod[OMAX_W+RECIP_W-1 -: DIVQ_W];

	// shared multiplier operand select
	always_comb begin
		mul_a = gain_i;
		mul_b = DW'(e_q);
		if (cmd.integ) begin
			mul_a = gain_p;
			mul_b = dp_q;
		end else if (cmd.mul_d) begin
			mul_a = gain_d;
			mul_b = dd_q;
		end
	end
	assign prod_d = PW'(mul_a) * PW'(mul_b);

	// integral update with the small-error clamp
	assign kie_small = (prod_q >= KIE_LO) && (prod_q <= KIE_HI);
	assign kie_r     = (prod_q + HALF_P) >>> GAIN_FRAC_W;
	assign integ_sum = RW'(integ_old) + kie_r[RW-1:0];
	assign integ_lim = kie_small ? LIM_SMALL : LIM_BIG;
	always_comb begin
		if (integ_sum > integ_lim) begin
			integ_new = INTEG_W'(integ_lim);
		end else if (integ_sum < -integ_lim) begin
			integ_new = INTEG_W'(-integ_lim);
		end else begin
			integ_new = INTEG_W'(integ_sum);
		end
	end

	// accumulator update, clamped to +-output_max in q.8
	assign sum_r   = (sum_q + HALF_S) >>> GAIN_FRAC_W;
	assign acc_sum = AW'(acc_old) + sum_r[AW-1:0];
	assign acc_lim = $signed(AW'({output_max, {FRAC_W{1'b0}}}));
	always_comb begin
		if (acc_sum > acc_lim) begin
			acc_new = ACC_W'(acc_lim);
		end else if (acc_sum < -acc_lim) begin
			acc_new = ACC_W'(-acc_lim);
		end else begin
			acc_new = ACC_W'(acc_sum);
		end
	end

	// pwm magnitude truncated toward zero, dead band applied
	assign acc_abs = acc_old[ACC_W-1] ? ACC_W'(-acc_old) : ACC_W'(acc_old);
	assign mag_raw = acc_abs[FRAC_W +: MAG_W];
	assign mag_db  = (mag_raw < dead_band) ? '0 : mag_raw;
	assign dir_ext = 16'(direction_mask);
	assign dir_bit = dir_ext[4'(idx_q)];

	// restoring divider, one quotient bit a cycle
	assign trial     = {rem_q, quo_q[MAG_W-1]};
	assign trial_sub = trial - {1'b0, divq_q};
	assign ge        = (trial >= {1'b0, divq_q});

	assign pct_full_w = MAG_W'(PCT_FULL);
	assign pct_mag    = (quo_q > pct_full_w) ? (PCT_W - 1)'(PCT_FULL) : quo_q[PCT_W-2:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			e_q    <= e_in;
			idx_q  <= motor_index;
			skip_q <= sts.skip;
		end
		if (cmd.diff) begin
			dp_q   <= DW'(e_q) - DW'(e1);
			dd_q   <= DW'(e_q) - (DW'(e1) <<< 1) + DW'(e2);
			divq_q <= divq_d;
		end
		if (cmd.mul_i || cmd.integ || cmd.mul_d) begin
			prod_q <= prod_d;
		end
		if (cmd.integ) begin
			integ_q <= integ_new;
		end
		if (cmd.mul_d) begin
			sum_q <= SUMW'(prod_q) + (SUMW'(integ_q) <<< GAIN_FRAC_W);
		end
		if (cmd.sum) begin
			sum_q <= sum_q + SUMW'(prod_q);
		end
		if (cmd.pwm) begin
			mag_q <= mag_db;
			quo_q <= mag_db;
			rem_q <= '0;
			neg_q <= acc_old[ACC_W-1] ^ dir_bit;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[DIVQ_W-1:0] : trial[DIVQ_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
		if (cmd.out_ld) begin
			if (skip_q) begin
				pwm_value     <= '0;
				drive_percent <= '0;
			end else begin
				pwm_value     <= neg_q ? -PWM_W'(mag_q) : PWM_W'(mag_q);
				drive_percent <= neg_q ? -PCT_W'(pct_mag) : PCT_W'(pct_mag);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				last_err_q[m]  <= '0;
				prev_err_q[m]  <= '0;
				integ_mem_q[m] <= '0;
				acc_mem_q[m]   <= '0;
			end
		end else if (cmd.acc) begin
			integ_mem_q[idx_q] <= integ_q;
			acc_mem_q[idx_q]   <= acc_new;
			prev_err_q[idx_q]  <= e1;
			last_err_q[idx_q]  <= e_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/wheel_speed_incremental_pid_core.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_incremental_pid_core
// incremental pid speed loop for several wheels with pwm and percent output
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry motor_index, target_speed,
//   measured_speed and stop; a transfer happens when in_valid is high and
//   in_stall is low. output channel: out_valid / out_stall carry pwm_value
//   and drive_percent, one result per input transfer, in order.
//   a normal item runs through the DIFF, MULI, INTEG, MULD, SUM, ACC, PWM and
//   DIV states before its result loads; a stop item or one with an out of
//   range motor index goes straight to the load, shows zeros and leaves the
//   loop state untouched. no new item is taken until the last one has loaded;
//   the pace is set by the single shared multiplier (three products per item)
//   and the 15 step restoring divider that forms the percent value.
//   the result sits in an output register; a stall from the receiver holds
//   it, and the core only waits if a finished result still finds it full.
//   reset clears all per-motor errors, integrals and accumulators at once
//   and loads the register defaults; there is no clearing pass. the user
//   must make configuration writes while no item is in flight, unchecked.
// ----------------------------------------------------------------------------
module wheel_speed_incremental_pid_core
	import wsip_pkg::*;
#(
	parameter  int MOTOR_COUNT = 4,
	parameter  int SPEED_WIDTH = 24,
	localparam int IDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_write,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [IDX_W-1:0]              motor_index,
	input  logic signed [SPEED_WIDTH-1:0] target_speed,
	input  logic signed [SPEED_WIDTH-1:0] measured_speed,
	input  logic                          stop,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [PWM_W-1:0]       pwm_value,
	output logic signed [PCT_W-1:0]       drive_percent
);

	// configuration registers
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic        [OMAX_W-1:0] output_max_q, dead_band_q;
	logic        [MASK_W-1:0] direction_mask_q;

	cmd_t cmd;
	sts_t sts;

	// writes to an index beyond the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= GAIN_P_RST;
			gain_i_q         <= GAIN_I_RST;
			gain_d_q         <= GAIN_D_RST;
			output_max_q     <= OUTPUT_MAX_RST;
			dead_band_q      <= DEAD_BAND_RST;
			direction_mask_q <= DIR_MASK_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GAIN_P:     gain_p_q         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:     gain_i_q         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:     gain_d_q         <= cfg_data[GAIN_W-1:0];
				REG_OUTPUT_MAX: output_max_q     <= cfg_data[OMAX_W-1:0];
				REG_DEAD_BAND:  dead_band_q      <= cfg_data[OMAX_W-1:0];
				REG_DIR_MASK:   direction_mask_q <= cfg_data[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: one item at a time through the datapath
	wsip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// loop state, multiplier, pwm shaping, divider and output register
	wsip_dpath #(
		.MOTOR_COUNT (MOTOR_COUNT),
		.SPEED_WIDTH (SPEED_WIDTH),
		.IDX_W       (IDX_W)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.gain_p         (gain_p_q),
		.gain_i         (gain_i_q),
		.gain_d         (gain_d_q),
		.output_max     (output_max_q),
		.dead_band      (dead_band_q),
		.direction_mask (direction_mask_q),
		.motor_index    (motor_index),
		.target_speed   (target_speed),
		.measured_speed (measured_speed),
		.stop           (stop),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.pwm_value      (pwm_value),
		.drive_percent  (drive_percent)
	);

endmodule

// ===== src/wsip_checker.sv =====
// ----------------------------------------------------------------------------
// wsip_checker
// port-level checks of the pid core, bound to the top level
// ----------------------------------------------------------------------------
`include "wheel_speed_incremental_pid_core_macros.svh"

module wsip_checker
	import wsip_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [PWM_W-1:0] pwm_value,
	input logic signed [PCT_W-1:0] drive_percent
);

	// a held result keeps its payload
	`WSIP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pwm_value) && $stable(drive_percent), "stalled result changed")

	// the percent never leaves its full-scale band
	`WSIP_ASSERT_IMP(a_pct_range, clk, arst_n, out_valid, (drive_percent <= 8'sd100) && (drive_percent >= -8'sd100), "percent out of range")

	// zero drive gives zero percent, and a nonzero percent has the pwm's sign
	`WSIP_ASSERT_IMP(a_pct_zero, clk, arst_n, out_valid && (pwm_value == '0), drive_percent == '0, "percent without drive")
	`WSIP_ASSERT_IMP(a_pct_sign, clk, arst_n, out_valid && (drive_percent != '0), pwm_value[PWM_W-1] == drive_percent[PCT_W-1], "percent sign differs from pwm")

	// one item at a time: a transfer makes the core busy in the next cycle
	`WSIP_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall, "second transfer before the first item ended")

endmodule

bind wheel_speed_incremental_pid_core wsip_checker u_wsip_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.pwm_value     (pwm_value),
	.drive_percent (drive_percent)
);
